// ===== rtl/mspfp_pkg.sv =====
`default_nettype none

package mspfp_pkg;

    localparam logic [7:0] SYNC_CHAR = 8'h24;   // '$'
    localparam logic [7:0] TYPE_V1   = 8'h4D;   // 'M'
    localparam logic [7:0] TYPE_V2   = 8'h58;   // 'X'

    localparam logic [15:0] V1_HEADER = 16'd5;
    localparam logic [15:0] V2_HEADER = 16'd8;

    localparam logic [15:0] MAX_FRAME_LEN_RESET = 16'd256;

    typedef enum logic [1:0] {
        ST_MORE = 2'd0,
        ST_OK   = 2'd1,
        ST_ERR  = 2'd2
    } t_status;

    typedef struct packed {
        t_status     status;
        logic        is_v2;
        logic [15:0] command;
        logic [15:0] payload_len;
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic [15:0] payload_index;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/mspfp_if.sv =====
`default_nettype none

// Received byte channel.
interface mspfp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Per-byte parser result channel.
interface mspfp_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        is_v2;
    logic [15:0] command;
    logic [15:0] payload_len;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic [15:0] payload_index;

    modport source (output valid, output status, output is_v2, output command,
                    output payload_len, output payload_byte, output payload_valid,
                    output payload_index, input ready);
    modport sink   (input valid, input status, input is_v2, input command,
                    input payload_len, input payload_byte, input payload_valid,
                    input payload_index, output ready);
endinterface

// Configuration write channel for the receive buffer size.
interface mspfp_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/mspfp_crc8.sv =====
`default_nettype none

// One byte of CRC-8 DVB-S2 (polynomial 0xD5), MSB first.
module mspfp_crc8 (
    input  wire logic [7:0] i_crc,
    input  wire logic [7:0] i_data,
    output logic      [7:0] o_crc
);

    always_comb begin
        logic [7:0] c;
        c = i_crc ^ i_data;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ 8'hD5;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        o_crc = c;
    end

endmodule

`default_nettype wire

// ===== rtl/mspfp_core.sv =====
`default_nettype none

// Frame state and the per-byte decision. The state advances on i_fire and
// o_result describes the byte on i_byte against the current state.
module mspfp_core
    import mspfp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_fire,
    input  wire logic [7:0]  i_byte,
    input  wire logic [15:0] i_max_frame_len,
    output t_result          o_result
);

    logic [15:0] r_byte_count, n_byte_count;
    logic [7:0]  r_frame_type, n_frame_type;
    logic [15:0] r_frame_command, n_frame_command;
    logic [15:0] r_frame_length, n_frame_length;
    logic [7:0]  r_xor_sum, n_xor_sum;
    logic [7:0]  r_crc_sum, n_crc_sum;

    logic [7:0]  crc_seed;
    logic [7:0]  crc_next;
    logic [15:0] rel_v1;
    logic [15:0] rel_v2;

    assign crc_seed = (r_byte_count == 16'd3) ? 8'h00 : r_crc_sum;
    assign rel_v1   = r_byte_count - V1_HEADER;
    assign rel_v2   = r_byte_count - V2_HEADER;

    mspfp_crc8 u_crc (
        .i_crc  (crc_seed),
        .i_data (i_byte),
        .o_crc  (crc_next)
    );

    always_comb begin
        n_byte_count    = r_byte_count;
        n_frame_type    = r_frame_type;
        n_frame_command = r_frame_command;
        n_frame_length  = r_frame_length;
        n_xor_sum       = r_xor_sum;
        n_crc_sum       = r_crc_sum;
        o_result        = '0;
        o_result.status = ST_MORE;

        if (r_byte_count >= i_max_frame_len) begin
            // Buffer full: the byte is dropped and the parser starts over.
            n_byte_count    = '0;
            o_result.status = ST_ERR;
        end else begin
            n_byte_count = r_byte_count + 16'd1;
            if (r_byte_count == 16'd0) begin
                if (i_byte != SYNC_CHAR) begin
                    n_byte_count    = '0;
                    o_result.status = ST_ERR;
                end
            end else if (r_byte_count == 16'd1) begin
                n_frame_type   = i_byte;
                o_result.is_v2 = (i_byte == TYPE_V2);
            end else if (r_frame_type == TYPE_V1) begin
                if (r_byte_count == 16'd3) begin
                    n_frame_length = {8'h00, i_byte};
                    n_xor_sum      = i_byte;
                end else if (r_byte_count == 16'd4) begin
                    n_frame_command = {8'h00, i_byte};
                    n_xor_sum       = r_xor_sum ^ i_byte;
                end else if (r_byte_count >= V1_HEADER) begin
                    if (rel_v1 < r_frame_length) begin
                        n_xor_sum              = r_xor_sum ^ i_byte;
                        o_result.payload_byte  = i_byte;
                        o_result.payload_valid = 1'b1;
                        o_result.payload_index = rel_v1;
                    end else begin
                        n_byte_count = '0;
                        if (i_byte == r_xor_sum) begin
                            o_result.status      = ST_OK;
                            o_result.command     = r_frame_command;
                            o_result.payload_len = r_frame_length;
                        end else begin
                            o_result.status = ST_ERR;
                        end
                    end
                end
            end else if (r_frame_type == TYPE_V2) begin
                o_result.is_v2 = 1'b1;
                if (r_byte_count >= 16'd3 && r_byte_count < V2_HEADER) begin
                    n_crc_sum = crc_next;
                    if (r_byte_count == 16'd4) begin
                        n_frame_command = {r_frame_command[15:8], i_byte};
                    end else if (r_byte_count == 16'd5) begin
                        n_frame_command = {i_byte, r_frame_command[7:0]};
                    end else if (r_byte_count == 16'd6) begin
                        n_frame_length = {r_frame_length[15:8], i_byte};
                    end else if (r_byte_count == 16'd7) begin
                        n_frame_length = {i_byte, r_frame_length[7:0]};
                    end
                end else if (r_byte_count >= V2_HEADER) begin
                    if (rel_v2 < r_frame_length) begin
                        n_crc_sum              = crc_next;
                        o_result.payload_byte  = i_byte;
                        o_result.payload_valid = 1'b1;
                        o_result.payload_index = rel_v2;
                    end else begin
                        n_byte_count = '0;
                        if (i_byte == r_crc_sum) begin
                            o_result.status      = ST_OK;
                            o_result.command     = r_frame_command;
                            o_result.payload_len = r_frame_length;
                        end else begin
                            o_result.status = ST_ERR;
                        end
                    end
                end
            end else begin
                // Unknown frame type, reported on the byte after it.
                n_byte_count    = '0;
                o_result.status = ST_ERR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count    <= '0;
            r_frame_type    <= '0;
            r_frame_command <= '0;
            r_frame_length  <= '0;
            r_xor_sum       <= '0;
            r_crc_sum       <= '0;
        end else if (i_fire) begin
            r_byte_count    <= n_byte_count;
            r_frame_type    <= n_frame_type;
            r_frame_command <= n_frame_command;
            r_frame_length  <= n_frame_length;
            r_xor_sum       <= n_xor_sum;
            r_crc_sum       <= n_crc_sum;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/msp_v1_v2_frame_parser_top.sv =====
`default_nettype none

// MSP v1/v2 receive frame parser. Bytes from the serial link arrive on i_rx,
// one per transfer, and every byte yields exactly one result transfer on
// o_res: need-more, frame-ok (with command and payload length) or error, with
// each payload byte passed through together with its index as it arrives.
// No frame buffer is held; a byte count, the header fields and a running XOR
// (v1) or CRC-8 DVB-S2 (v2) checksum are enough. The block sustains one byte
// per clock cycle while o_res is not stalled: a byte is captured in an input
// register, then decided by the parser state and written to the result
// register. The receive buffer size (reset value 256) is written through
// i_cfg, which is always ready, and should only be changed while no byte is
// in flight.
module msp_v1_v2_frame_parser_top
    import mspfp_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mspfp_rx_if.sink    i_rx,
    mspfp_cfg_if.sink   i_cfg,
    mspfp_res_if.source o_res
);

    logic [15:0] r_max_frame_len;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    logic        r_out_valid;
    t_result     r_out;

    t_result     step_result;
    logic        advance;

    // The configuration port never stalls.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_frame_len <= MAX_FRAME_LEN_RESET;
        end else if (i_cfg.valid) begin
            r_max_frame_len <= i_cfg.data;
        end
    end

    // A captured byte moves on once the result register is free or is being
    // emptied in this cycle; the input register then takes the next byte in
    // the same cycle, so a result that leaves in this cycle does not hold up a
    // fresh transfer. While a full result register is stalled, a captured
    // byte waits and the input is not ready.
    assign advance    = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_rx.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    mspfp_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (advance),
        .i_byte          (r_in_byte),
        .i_max_frame_len (r_max_frame_len),
        .o_result        (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_result;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.status        = r_out.status;
    assign o_res.is_v2         = r_out.is_v2;
    assign o_res.command       = r_out.command;
    assign o_res.payload_len   = r_out.payload_len;
    assign o_res.payload_byte  = r_out.payload_byte;
    assign o_res.payload_valid = r_out.payload_valid;
    assign o_res.payload_index = r_out.payload_index;

endmodule

`default_nettype wire
